// ===== hw/rtl/scan_object_segmenter_top_assert.svh =====
// assertion macros shared by the segmenter modules
// each macro expects clk and rst_n in the scope where it is used
`ifndef SCAN_OBJECT_SEGMENTER_TOP_ASSERT_SVH
`define SCAN_OBJECT_SEGMENTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// condition implies property in the same cycle
`define SOS_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("segmenter assertion failed");
// condition implies property in the next cycle
`define SOS_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("segmenter assertion failed");
`else
`define SOS_ASSERT_IMP(label, cond, prop)
`define SOS_ASSERT_NXT(label, cond, prop)
`endif
`endif

// ===== hw/rtl/sos_pkg.sv =====
package sos_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_DISTANCE   = 2'd0;
    localparam logic [1:0] REG_MAX_DISTANCE   = 2'd1;
    localparam logic [1:0] REG_MAX_JUMP       = 2'd2;
    localparam logic [1:0] REG_MIN_RUN_POINTS = 2'd3;

    // fixed result widths
    localparam int MEAN_W = 20;
    localparam int Q_W    = 21;
    // sine table entries are Q14, up to 16384
    localparam int SIN_W  = 15;
    // count * 10 * 16384 needs 8 + 18 bits
    localparam int DEN_W  = 26;

    // angle folding for the half-angle sine
    localparam logic [7:0] HALF_TURN = 8'd180;
    localparam logic [8:0] FULL_TURN = 9'd360;
    localparam logic [6:0] SIN_LAST  = 7'd90;

    // sin(k degrees) in Q14, k = 0..90, rounded to nearest
    localparam logic [14:0] SIN_Q14 [91] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    // arithmetic unit sequencer
    typedef enum logic [2:0] {
        CALC_IDLE,
        CALC_SETUP,
        CALC_MUL,
        CALC_DIV_MEAN,
        CALC_DIV_WIDTH,
        CALC_DONE
    } calc_state_t;

    // front end to arithmetic unit
    typedef struct packed {
        logic start;
        logic take;
    } calc_ctrl_t;

    // arithmetic unit to front end
    typedef struct packed {
        logic idle;
        logic done;
    } calc_stat_t;

endpackage

// ===== hw/rtl/sos_if.sv =====
// scan point channel
interface sos_point_if;
    logic        valid;
    logic        ready;
    logic [7:0]  point_angle;
    logic [15:0] point_distance;
    logic        last_point;

    modport source (output valid, output point_angle, output point_distance,
                    output last_point, input ready);
    modport sink (input valid, input point_angle, input point_distance,
                  input last_point, output ready);
endinterface

// object result channel
interface sos_object_if;
    logic        valid;
    logic        ready;
    logic [7:0]  start_angle;
    logic [8:0]  center_angle_half;
    logic [7:0]  point_count;
    logic [19:0] mean_distance_q4;
    logic [20:0] width_q4;

    modport source (output valid, output start_angle, output center_angle_half,
                    output point_count, output mean_distance_q4, output width_q4,
                    input ready);
    modport sink (input valid, input start_angle, input center_angle_half,
                  input point_count, input mean_distance_q4, input width_q4,
                  output ready);
endinterface

// ===== hw/rtl/sos_calc.sv =====
`include "scan_object_segmenter_top_assert.svh"

module sos_calc #(
    parameter int DIST_BITS = 16,
    parameter int FRAC_BITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sos_pkg::calc_ctrl_t           ctrl,
    output sos_pkg::calc_stat_t           stat,
    input  logic [7:0]                    job_start_angle,
    input  logic [7:0]                    job_end_angle,
    input  logic [DIST_BITS+7:0]          job_sum,
    input  logic [7:0]                    job_count,
    output logic [7:0]                    res_start_angle,
    output logic [8:0]                    res_center_half,
    output logic [7:0]                    res_count,
    output logic [sos_pkg::MEAN_W-1:0]    res_mean,
    output logic [sos_pkg::Q_W-1:0]       res_width
);

    localparam int SUM_W   = DIST_BITS + 8;
    localparam int MCAND_W = SUM_W + 4;
    localparam int PROD_W  = MCAND_W + sos_pkg::SIN_W;
    localparam int NUM_W   = PROD_W + FRAC_BITS;
    localparam int DEN_W   = sos_pkg::DEN_W;
    localparam int Q_W     = sos_pkg::Q_W;
    localparam int MEAN_W  = sos_pkg::MEAN_W;
    localparam int SIN_W   = sos_pkg::SIN_W;
    localparam int CNT_W   = $clog2(NUM_W);

    sos_pkg::calc_state_t state_reg, state_next;

    logic [7:0]         start_a_reg;
    logic [7:0]         end_a_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [7:0]         cnt_reg;
    logic [8:0]         center_reg;
    logic [SIN_W-1:0]   sin_sr_reg;
    logic [MCAND_W-1:0] mcand_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [NUM_W-1:0]   num_sr_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [Q_W-1:0]     q_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   bcnt_reg;
    logic [MEAN_W-1:0]  mean_reg;
    logic [Q_W-1:0]     width_reg;

    logic               mul_last;
    logic               div_last;

    // half-angle sine and centre
    logic [7:0]         span;
    logic [8:0]         span_fold9;
    logic [7:0]         span_fold;
    logic [6:0]         sin_h;
    logic [6:0]         sin_h1;
    logic [15:0]        sin_avg;
    logic [SIN_W-1:0]   sin_val;
    logic [8:0]         center_val;
    logic [MCAND_W-1:0] sum_ext;
    logic [MCAND_W-1:0] sum_x11;
    logic [DEN_W-1:0]   cnt_ext;
    logic [DEN_W-1:0]   den_width;

    always_comb
    begin
        span       = (end_a_reg >= start_a_reg) ? end_a_reg - start_a_reg : 8'd0;
        span_fold9 = (span > sos_pkg::HALF_TURN) ? sos_pkg::FULL_TURN - 9'(span)
                                                 : 9'(span);
        span_fold  = span_fold9[7:0];
        sin_h      = span_fold[7:1];
        sin_h1     = (sin_h == sos_pkg::SIN_LAST) ? sin_h : sin_h + 7'd1;
        sin_avg    = 16'(sos_pkg::SIN_Q14[sin_h]) + 16'(sos_pkg::SIN_Q14[sin_h1]);
        sin_val    = span_fold[0] ? sin_avg[15:1] : sos_pkg::SIN_Q14[sin_h];
        center_val = {start_a_reg, 1'b0} + 9'(span);
        sum_ext    = MCAND_W'(sum_reg);
        sum_x11    = (sum_ext << 3) + (sum_ext << 1) + sum_ext;
        cnt_ext    = DEN_W'(cnt_reg);
        // count * 10 * 16384
        den_width  = (cnt_ext << 17) + (cnt_ext << 15);
    end

    // one restoring division step per cycle
    logic [DEN_W:0]     r_sh;
    logic [DEN_W:0]     r_sub;
    logic               q_bit;
    logic [DEN_W-1:0]   rem_step;
    logic [Q_W-1:0]     q_step;
    logic               ovf_step;
    logic [MEAN_W-1:0]  mean_sat;
    logic [Q_W-1:0]     width_sat;

    always_comb
    begin
        r_sh      = {rem_reg, num_sr_reg[NUM_W-1]};
        r_sub     = r_sh - {1'b0, den_reg};
        q_bit     = (r_sh >= {1'b0, den_reg});
        rem_step  = q_bit ? r_sub[DEN_W-1:0] : r_sh[DEN_W-1:0];
        q_step    = {q_reg[Q_W-2:0], q_bit};
        ovf_step  = ovf_reg | q_reg[Q_W-1];
        mean_sat  = (ovf_step || q_step[Q_W-1]) ? '1 : q_step[MEAN_W-1:0];
        width_sat = ovf_step ? '1 : q_step;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sos_pkg::CALC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sos_pkg::CALC_IDLE:
                if (ctrl.start)
                    state_next = sos_pkg::CALC_SETUP;
            sos_pkg::CALC_SETUP:
                state_next = sos_pkg::CALC_MUL;
            sos_pkg::CALC_MUL:
                if (mul_last)
                    state_next = sos_pkg::CALC_DIV_MEAN;
            sos_pkg::CALC_DIV_MEAN:
                if (div_last)
                    state_next = sos_pkg::CALC_DIV_WIDTH;
            sos_pkg::CALC_DIV_WIDTH:
                if (div_last)
                    state_next = sos_pkg::CALC_DONE;
            sos_pkg::CALC_DONE:
                if (ctrl.take)
                    state_next = sos_pkg::CALC_IDLE;
            default:
                state_next = sos_pkg::CALC_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        stat.idle = 1'b0;
        stat.done = 1'b0;
        mul_last  = 1'b0;
        div_last  = 1'b0;
        unique case (state_reg)
            sos_pkg::CALC_IDLE:
                stat.idle = 1'b1;
            sos_pkg::CALC_MUL:
                mul_last = (bcnt_reg == CNT_W'(SIN_W - 1));
            sos_pkg::CALC_DIV_MEAN,
            sos_pkg::CALC_DIV_WIDTH:
                div_last = (bcnt_reg == CNT_W'(NUM_W - 1));
            sos_pkg::CALC_DONE:
                stat.done = 1'b1;
            default:
            begin
            end
        endcase
    end

    // serial datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            sos_pkg::CALC_IDLE:
                if (ctrl.start)
                begin
                    start_a_reg <= job_start_angle;
                    end_a_reg   <= job_end_angle;
                    sum_reg     <= job_sum;
                    cnt_reg     <= job_count;
                end
            sos_pkg::CALC_SETUP:
            begin
                center_reg <= center_val;
                sin_sr_reg <= sin_val;
                mcand_reg  <= sum_x11;
                acc_reg    <= '0;
                num_sr_reg <= NUM_W'(sum_reg) << FRAC_BITS;
                den_reg    <= cnt_ext;
                rem_reg    <= '0;
                q_reg      <= '0;
                ovf_reg    <= 1'b0;
                bcnt_reg   <= '0;
            end
            sos_pkg::CALC_MUL:
            begin
                // shift-add, multiplier bits msb first
                acc_reg    <= (acc_reg << 1)
                              + (sin_sr_reg[SIN_W-1] ? PROD_W'(mcand_reg) : '0);
                sin_sr_reg <= sin_sr_reg << 1;
                bcnt_reg   <= mul_last ? '0 : bcnt_reg + CNT_W'(1);
            end
            sos_pkg::CALC_DIV_MEAN:
                if (div_last)
                begin
                    mean_reg   <= mean_sat;
                    num_sr_reg <= NUM_W'(acc_reg) << FRAC_BITS;
                    den_reg    <= den_width;
                    rem_reg    <= '0;
                    q_reg      <= '0;
                    ovf_reg    <= 1'b0;
                    bcnt_reg   <= '0;
                end
                else
                begin
                    num_sr_reg <= num_sr_reg << 1;
                    rem_reg    <= rem_step;
                    q_reg      <= q_step;
                    ovf_reg    <= ovf_step;
                    bcnt_reg   <= bcnt_reg + CNT_W'(1);
                end
            sos_pkg::CALC_DIV_WIDTH:
                if (div_last)
                begin
                    width_reg <= width_sat;
                    bcnt_reg  <= '0;
                end
                else
                begin
                    num_sr_reg <= num_sr_reg << 1;
                    rem_reg    <= rem_step;
                    q_reg      <= q_step;
                    ovf_reg    <= ovf_step;
                    bcnt_reg   <= bcnt_reg + CNT_W'(1);
                end
            default:
            begin
            end
        endcase
    end

    assign res_start_angle = start_a_reg;
    assign res_center_half = center_reg;
    assign res_count       = cnt_reg;
    assign res_mean        = mean_reg;
    assign res_width       = width_reg;

    `SOS_ASSERT_IMP(a_start_when_idle, ctrl.start, state_reg == sos_pkg::CALC_IDLE)
    `SOS_ASSERT_IMP(a_take_when_done, ctrl.take, state_reg == sos_pkg::CALC_DONE)
    `SOS_ASSERT_IMP(a_rem_below_den, (state_reg == sos_pkg::CALC_DIV_MEAN) || (state_reg == sos_pkg::CALC_DIV_WIDTH), rem_reg < den_reg)
    `SOS_ASSERT_NXT(a_done_holds, (state_reg == sos_pkg::CALC_DONE) && !ctrl.take, state_reg == sos_pkg::CALC_DONE)

endmodule

// ===== hw/rtl/scan_object_segmenter_top.sv =====
// Range-scan object segmenter.
// points: one beat per scan point (angle, distance, last_point), rising angles.
// objects: one beat per object found (start angle, centre in half degrees,
//   point count, mean distance and width, both with FRAC_BITS fraction bits).
// cfg_we/cfg_index/cfg_data write the window, jump limit and minimum run length;
//   write them only while no object is being computed.
// A point that closes no long-enough run is taken while the serial unit is idle;
//   such points then stream back to back.
// A point that closes an object starts the shared serial unit: a setup step, a
//   shift-add sine multiply and two restoring divisions over NUM_W =
//   DIST_BITS + FRAC_BITS + 27 numerator bits (mean, then width), then a hand-off
//   to the output register; points.ready is low until the hand-off.
// The result waits in an output register; while objects.ready is low, points
//   are still taken unless a second object is finished and waiting behind it.
// Reset clears the open run, the output register and the unit, and loads the
//   register defaults 5, 400, 10 and 2.
`include "scan_object_segmenter_top_assert.svh"

module scan_object_segmenter_top #(
    parameter int DIST_BITS = 16,
    parameter int ANGLE_MAX = 180,
    parameter int FRAC_BITS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    sos_point_if.sink    points,
    sos_object_if.source objects
);

    localparam int SUM_W = DIST_BITS + 8;
    localparam int CW    = (DIST_BITS > 16) ? DIST_BITS : 16;

    localparam logic [7:0]  ANGLE_LIM     = 8'(ANGLE_MAX);
    localparam logic [7:0]  RUN_FLOOR     = 8'd2;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;
    localparam logic [15:0] MIN_DIST_RST  = 16'd5;
    localparam logic [15:0] MAX_DIST_RST  = 16'd400;
    localparam logic [15:0] MAX_JUMP_RST  = 16'd10;
    localparam logic [7:0]  MIN_RUN_RST   = 8'd2;

    logic [15:0] min_dist_reg;
    logic [15:0] max_dist_reg;
    logic [15:0] max_jump_reg;
    logic [7:0]  min_run_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= MIN_DIST_RST;
            max_dist_reg <= MAX_DIST_RST;
            max_jump_reg <= MAX_JUMP_RST;
            min_run_reg  <= MIN_RUN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sos_pkg::REG_MIN_DISTANCE:   min_dist_reg <= cfg_data;
                sos_pkg::REG_MAX_DISTANCE:   max_dist_reg <= cfg_data;
                sos_pkg::REG_MAX_JUMP:       max_jump_reg <= cfg_data;
                sos_pkg::REG_MIN_RUN_POINTS: min_run_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // open run
    logic                 run_active_reg, run_active_next;
    logic [7:0]           run_count_reg, run_count_next;
    logic [7:0]           run_start_reg, run_start_next;
    logic [7:0]           run_end_reg, run_end_next;
    logic [DIST_BITS-1:0] run_last_reg, run_last_next;
    logic [SUM_W-1:0]     run_sum_reg, run_sum_next;

    sos_pkg::calc_ctrl_t  ctrl;
    sos_pkg::calc_stat_t  stat;

    logic                 accept;
    logic [7:0]           ang;
    logic [CW-1:0]        dist_ext;
    logic [DIST_BITS-1:0] pt_dist;
    logic [DIST_BITS-1:0] diff;
    logic                 in_window;
    logic                 cont;
    logic [7:0]           need;
    logic                 upd_active;
    logic [7:0]           upd_start;
    logic [7:0]           upd_end;
    logic [DIST_BITS-1:0] upd_last;
    logic [SUM_W-1:0]     upd_sum;
    logic [7:0]           upd_count;
    logic                 emit_close;
    logic                 emit_last;
    logic [7:0]           job_start;
    logic [7:0]           job_end;
    logic [SUM_W-1:0]     job_sum;
    logic [7:0]           job_count;

    assign accept = points.valid && points.ready;
    assign points.ready = stat.idle;

    // point classification
    always_comb
    begin
        ang       = (points.point_angle > ANGLE_LIM) ? ANGLE_LIM : points.point_angle;
        dist_ext  = CW'(points.point_distance);
        pt_dist   = dist_ext[DIST_BITS-1:0];
        in_window = (CW'(pt_dist) >= CW'(min_dist_reg)) && (CW'(pt_dist) <= CW'(max_dist_reg));
        diff      = (pt_dist >= run_last_reg) ? pt_dist - run_last_reg : run_last_reg - pt_dist;
        cont      = run_active_reg && (CW'(diff) < CW'(max_jump_reg));
        need      = (min_run_reg < RUN_FLOOR) ? RUN_FLOOR : min_run_reg;
    end

    // run after this point, before the end-of-scan flush
    always_comb
    begin
        upd_active = 1'b0;
        upd_start  = run_start_reg;
        upd_end    = run_end_reg;
        upd_last   = run_last_reg;
        upd_sum    = run_sum_reg;
        upd_count  = 8'd0;
        if (in_window && cont)
        begin
            upd_active = 1'b1;
            upd_end    = ang;
            upd_last   = pt_dist;
            upd_count  = run_count_reg;
            // a saturated run keeps its sum and count
            if (run_count_reg != COUNT_MAX)
            begin
                upd_sum   = run_sum_reg + SUM_W'(pt_dist);
                upd_count = run_count_reg + 8'd1;
            end
        end
        else if (in_window)
        begin
            upd_active = 1'b1;
            upd_start  = ang;
            upd_end    = ang;
            upd_last   = pt_dist;
            upd_sum    = SUM_W'(pt_dist);
            upd_count  = 8'd1;
        end
    end

    // object emission: a closed run, or the flushed run at end of scan
    always_comb
    begin
        emit_close = run_active_reg && (run_count_reg >= need) && !(in_window && cont);
        emit_last  = points.last_point && !emit_close && upd_active && (upd_count >= need);
        job_start  = emit_close ? run_start_reg : upd_start;
        job_end    = emit_close ? run_end_reg   : upd_end;
        job_sum    = emit_close ? run_sum_reg   : upd_sum;
        job_count  = emit_close ? run_count_reg : upd_count;
    end

    always_comb
    begin
        run_active_next = run_active_reg;
        run_count_next  = run_count_reg;
        run_start_next  = run_start_reg;
        run_end_next    = run_end_reg;
        run_last_next   = run_last_reg;
        run_sum_next    = run_sum_reg;
        if (accept)
        begin
            run_active_next = upd_active && !points.last_point;
            run_count_next  = points.last_point ? 8'd0 : upd_count;
            run_start_next  = upd_start;
            run_end_next    = upd_end;
            run_last_next   = upd_last;
            run_sum_next    = upd_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            run_count_reg  <= 8'd0;
        end
        else
        begin
            run_active_reg <= run_active_next;
            run_count_reg  <= run_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_start_reg <= run_start_next;
        run_end_reg   <= run_end_next;
        run_last_reg  <= run_last_next;
        run_sum_reg   <= run_sum_next;
    end

    // serial mean and width unit
    logic [7:0]                 res_start_angle;
    logic [8:0]                 res_center_half;
    logic [7:0]                 res_count;
    logic [sos_pkg::MEAN_W-1:0] res_mean;
    logic [sos_pkg::Q_W-1:0]    res_width;

    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_start_reg;
    logic [8:0]                 out_center_reg;
    logic [7:0]                 out_count_reg;
    logic [sos_pkg::MEAN_W-1:0] out_mean_reg;
    logic [sos_pkg::Q_W-1:0]    out_width_reg;

    assign ctrl.start = accept && (emit_close || emit_last);
    assign ctrl.take  = stat.done && (!out_valid_reg || objects.ready);

    sos_calc #(
        .DIST_BITS (DIST_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_calc (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .stat            (stat),
        .job_start_angle (job_start),
        .job_end_angle   (job_end),
        .job_sum         (job_sum),
        .job_count       (job_count),
        .res_start_angle (res_start_angle),
        .res_center_half (res_center_half),
        .res_count       (res_count),
        .res_mean        (res_mean),
        .res_width       (res_width)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.take)
            out_valid_next = 1'b1;
        else if (objects.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            out_start_reg  <= res_start_angle;
            out_center_reg <= res_center_half;
            out_count_reg  <= res_count;
            out_mean_reg   <= res_mean;
            out_width_reg  <= res_width;
        end
    end

    assign objects.valid             = out_valid_reg;
    assign objects.start_angle       = out_start_reg;
    assign objects.center_angle_half = out_center_reg;
    assign objects.point_count       = out_count_reg;
    assign objects.mean_distance_q4  = out_mean_reg;
    assign objects.width_q4          = out_width_reg;

endmodule
